@@ design/hmq_pkg.sv @@
// Shared types, constants and helpers for the binary min-heap queue.
`default_nettype none

package hmq_pkg;

    // Heap sizing.
    localparam int CAPACITY = 1024;
    localparam int KEY_BITS = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Port field widths.
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;
    localparam int IN_KEY_W = 64;

    // Action codes carried on the input channel.
    typedef enum logic [ACTION_W-1:0] {
        ACT_ENQ  = 2'd0,
        ACT_DEQ  = 2'd1,
        ACT_PEEK = 2'd2
    } t_action;

    // Status codes returned on the output channel.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_UP,
        S_UP_CMP,
        S_ROOT,
        S_LAST,
        S_DN,
        S_DN_L,
        S_DN_R,
        S_OUT
    } t_state;

    // One access cycle of the heap store: a write and a read port.
    typedef struct packed {
        logic                wr_en;
        logic [ADDR_W-1:0]   wr_addr;
        logic [KEY_BITS-1:0] wr_data;
        logic                rd_en;
        logic [ADDR_W-1:0]   rd_addr;
    } t_mem_cmd;

    // One finished result transaction.
    typedef struct packed {
        t_status             status;
        logic [IN_KEY_W-1:0] result_key;
        logic [CNT_W-1:0]    entry_count;
    } t_res;

    // Zero-extend a stored key to the port width.
    function automatic logic [IN_KEY_W-1:0] widen_key(input logic [KEY_BITS-1:0] k);
        logic [IN_KEY_W-1:0] w;
        w              = '0;
        w[KEY_BITS-1:0] = k;
        return w;
    endfunction

endpackage

`default_nettype wire

@@ design/binary_min_heap_queue.sv @@
// Top level of the binary min-heap queue: sequencer, key store and output register.
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+---------------------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_action, i_key
//  out     | output    | o_out_valid / i_out_stall | o_status, o_result_key, o_entry_count
//
// A transaction holds the sequencer from its accepting cycle until its result is taken:
// a peek reads the root; an enqueue climbs the key level by level toward the root;
// a dequeue moves the last entry to the root and sinks it level by level, reading the
// children of each level one after the other, and goes straight to its result when it removes the last key.
// The key store has a single read port, so parents and children are fetched one at a time.
// Reset empties the heap by clearing the count; stored keys are not cleared.
// One transaction is worked on at a time; a finished result waits in the output
// register while the next transaction is accepted and processed.
`default_nettype none

module binary_min_heap_queue (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [hmq_pkg::ACTION_W-1:0] i_action,
    input  wire logic [hmq_pkg::IN_KEY_W-1:0] i_key,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [hmq_pkg::STATUS_W-1:0]      o_status,
    output logic [hmq_pkg::IN_KEY_W-1:0]      o_result_key,
    output logic [hmq_pkg::CNT_W-1:0]         o_entry_count
);
    import hmq_pkg::*;

    t_mem_cmd            mem_cmd;
    logic [KEY_BITS-1:0] rd_data;
    logic                ctrl_ready;
    logic                res_valid;
    t_res                res;
    logic                start;
    logic                load;
    logic                r_out_valid;
    t_res                r_out;

    // Input transaction acceptance.
    assign o_in_stall = !ctrl_ready;
    assign start      = i_in_valid && ctrl_ready;

    // The output register takes a result when empty or being drained.
    assign load = res_valid && (!r_out_valid || !i_out_stall);

    hmq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_action    (i_action),
        .i_key       (i_key),
        .i_res_taken (load),
        .i_rd_data   (rd_data),
        .o_mem       (mem_cmd),
        .o_ready     (ctrl_ready),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    hmq_store u_store (
        .i_clk     (i_clk),
        .i_cmd     (mem_cmd),
        .o_rd_data (rd_data)
    );

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out.status;
    assign o_result_key  = r_out.result_key;
    assign o_entry_count = r_out.entry_count;

endmodule

`default_nettype wire

@@ design/hmq_store.sv @@
// Heap key store: one write port and one read port with a registered read.
`default_nettype none

module hmq_store (
    input  wire logic                        i_clk,
    input  wire hmq_pkg::t_mem_cmd           i_cmd,
    output logic [hmq_pkg::KEY_BITS-1:0]     o_rd_data
);
    import hmq_pkg::*;

    logic [KEY_BITS-1:0] r_mem [CAPACITY];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= i_cmd.wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            o_rd_data <= r_mem[i_cmd.rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ design/hmq_ctrl.sv @@
// Heap sequencer: decodes actions and walks sift-up and sift-down over the store.
`default_nettype none

module hmq_ctrl (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [hmq_pkg::ACTION_W-1:0] i_action,
    input  wire logic [hmq_pkg::IN_KEY_W-1:0] i_key,
    input  wire logic                         i_res_taken,
    input  wire logic [hmq_pkg::KEY_BITS-1:0] i_rd_data,
    output hmq_pkg::t_mem_cmd                 o_mem,
    output logic                              o_ready,
    output logic                              o_res_valid,
    output hmq_pkg::t_res                     o_res
);
    import hmq_pkg::*;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    t_state              r_state, n_state;
    t_action             r_act, n_act;
    t_status             r_status, n_status;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [ADDR_W-1:0]   r_hole, n_hole;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [KEY_BITS-1:0] r_left, n_left;
    logic [KEY_BITS-1:0] r_result, n_result;

    logic [ADDR_W-1:0]   par_addr, gpar_addr;
    logic [ADDR_W+1:0]   left_idx, right_idx, cnt_ext;
    logic                has_left, has_right;
    logic                up_move, dn_l_move, dn_r_move, pick_right;
    logic [KEY_BITS-1:0] pick_val;
    logic [ADDR_W-1:0]   pick_idx;
    logic [CNT_W-1:0]    cnt_dec;
    t_action             act_in;

    // Index arithmetic for parent and child slots of the hole.
    assign par_addr  = (r_hole - ADDR_W'(1)) >> 1;
    assign gpar_addr = (par_addr - ADDR_W'(1)) >> 1;
    assign left_idx  = {1'b0, r_hole, 1'b1};
    assign right_idx = left_idx + (ADDR_W+2)'(1);
    assign cnt_ext   = (ADDR_W+2)'(r_cnt);
    assign has_left  = left_idx < cnt_ext;
    assign has_right = right_idx < cnt_ext;
    assign cnt_dec   = r_cnt - CNT_W'(1);
    assign act_in    = t_action'(i_action);

    // Key comparisons against the data just read from the store.
    assign up_move    = r_key < i_rd_data;
    assign dn_l_move  = r_key > i_rd_data;
    assign pick_right = !(r_left < i_rd_data);
    assign pick_val   = pick_right ? i_rd_data : r_left;
    assign pick_idx   = pick_right ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];
    assign dn_r_move  = r_key > pick_val;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (act_in) inside
                        ACT_ENQ:           n_state = (r_cnt == CAP_CNT) ? S_OUT : S_UP;
                        ACT_DEQ, ACT_PEEK: n_state = (r_cnt == '0) ? S_OUT : S_ROOT;
                        default:           n_state = S_OUT;
                    endcase
                end
            end
            S_UP:     n_state = (r_hole == '0) ? S_OUT : S_UP_CMP;
            S_UP_CMP: begin
                if (up_move && par_addr != '0) begin
                    n_state = S_UP_CMP;
                end else if (up_move) begin
                    n_state = S_UP;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_ROOT: begin
                if (r_act == ACT_PEEK || r_cnt == CNT_W'(1)) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_LAST;
                end
            end
            S_LAST:   n_state = S_DN;
            S_DN:     n_state = has_left ? S_DN_L : S_OUT;
            S_DN_L: begin
                if (has_right) begin
                    n_state = S_DN_R;
                end else begin
                    n_state = dn_l_move ? S_DN : S_OUT;
                end
            end
            S_DN_R:   n_state = dn_r_move ? S_DN : S_OUT;
            S_OUT:    n_state = i_res_taken ? S_IDLE : S_OUT;
            default:  n_state = S_IDLE;
        endcase
    end

    // Store accesses and datapath register updates for each state.
    always_comb begin
        n_act    = r_act;
        n_status = r_status;
        n_cnt    = r_cnt;
        n_hole   = r_hole;
        n_key    = r_key;
        n_left   = r_left;
        n_result = r_result;
        o_mem    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_act    = act_in;
                    n_status = ST_OK;
                    n_result = '0;
                    unique case (act_in) inside
                        ACT_ENQ: begin
                            if (r_cnt == CAP_CNT) begin
                                n_status = ST_FULL;
                            end else begin
                                n_key  = i_key[KEY_BITS-1:0];
                                n_hole = r_cnt[ADDR_W-1:0];
                                n_cnt  = r_cnt + CNT_W'(1);
                            end
                        end
                        ACT_DEQ, ACT_PEEK: begin
                            if (r_cnt == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                o_mem.rd_en   = 1'b1;
                                o_mem.rd_addr = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_UP: begin
                // Place the key at the root, or fetch the parent of the hole.
                if (r_hole == '0) begin
                    o_mem.wr_en   = 1'b1;
                    o_mem.wr_addr = r_hole;
                    o_mem.wr_data = r_key;
                end else begin
                    o_mem.rd_en   = 1'b1;
                    o_mem.rd_addr = par_addr;
                end
            end
            S_UP_CMP: begin
                // Move a larger parent into the hole and fetch the next one above it, else place the key.
                if (up_move) begin
                    o_mem.wr_en   = 1'b1;
                    o_mem.wr_addr = r_hole;
                    o_mem.wr_data = i_rd_data;
                    n_hole        = par_addr;
                    if (par_addr != '0) begin
                        o_mem.rd_en   = 1'b1;
                        o_mem.rd_addr = gpar_addr;
                    end
                end else begin
                    o_mem.wr_en   = 1'b1;
                    o_mem.wr_addr = r_hole;
                    o_mem.wr_data = r_key;
                end
            end
            S_ROOT: begin
                // Root arrives; a dequeue of more than one entry then fetches the last entry.
                n_result = i_rd_data;
                if (r_act == ACT_DEQ) begin
                    n_cnt  = cnt_dec;
                    n_hole = '0;
                    if (r_cnt != CNT_W'(1)) begin
                        o_mem.rd_en   = 1'b1;
                        o_mem.rd_addr = cnt_dec[ADDR_W-1:0];
                    end
                end
            end
            S_LAST: begin
                n_key = i_rd_data;
            end
            S_DN: begin
                if (has_left) begin
                    o_mem.rd_en   = 1'b1;
                    o_mem.rd_addr = left_idx[ADDR_W-1:0];
                end else begin
                    o_mem.wr_en   = 1'b1;
                    o_mem.wr_addr = r_hole;
                    o_mem.wr_data = r_key;
                end
            end
            S_DN_L: begin
                if (has_right) begin
                    n_left        = i_rd_data;
                    o_mem.rd_en   = 1'b1;
                    o_mem.rd_addr = right_idx[ADDR_W-1:0];
                end else if (dn_l_move) begin
                    o_mem.wr_en   = 1'b1;
                    o_mem.wr_addr = r_hole;
                    o_mem.wr_data = i_rd_data;
                    n_hole        = left_idx[ADDR_W-1:0];
                end else begin
                    o_mem.wr_en   = 1'b1;
                    o_mem.wr_addr = r_hole;
                    o_mem.wr_data = r_key;
                end
            end
            S_DN_R: begin
                // Ties between the children go to the right one.
                o_mem.wr_en   = 1'b1;
                o_mem.wr_addr = r_hole;
                if (dn_r_move) begin
                    o_mem.wr_data = pick_val;
                    n_hole        = pick_idx;
                end else begin
                    o_mem.wr_data = r_key;
                end
            end
            S_OUT: ;
            default: ;
        endcase
    end

    // Handshake and result outputs.
    always_comb begin
        o_ready               = (r_state == S_IDLE);
        o_res_valid           = (r_state == S_OUT);
        o_res.status          = r_status;
        o_res.result_key      = widen_key(r_result);
        o_res.entry_count     = r_cnt;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_act    <= n_act;
        r_status <= n_status;
        r_hole   <= n_hole;
        r_key    <= n_key;
        r_left   <= n_left;
        r_result <= n_result;
    end

    // The count never passes the capacity.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CAP_CNT)
        else $error("heap count exceeds capacity");

    // Every store write lands inside the live part of the heap.
    a_wr_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem.wr_en |-> (CNT_W'(o_mem.wr_addr) < r_cnt))
        else $error("store write beyond held count");

    // A sift-up step always moves the hole toward the root.
    a_up_climbs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UP_CMP && up_move) |=> (r_hole < $past(r_hole)))
        else $error("sift-up did not climb");

    // A transaction accepted while idle starts work at once.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && r_state == S_IDLE) |=> (r_state != S_IDLE))
        else $error("accepted transaction left the sequencer idle");

endmodule

`default_nettype wire

@@ test/binary_min_heap_queue_tb.sv @@
// Self-checking testbench for the binary min-heap queue with a scoreboard-based heap predictor.
module binary_min_heap_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hmq_pkg::*;

    // The one action code that the block treats as a no-op.
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam logic [IN_KEY_W-1:0] KEY_ONES   = '1;
    localparam logic [IN_KEY_W-1:0] KEY_TOP    = {1'b1, {(IN_KEY_W-1){1'b0}}};
    localparam int SETTLE_CYCLES = 60;

    // Mirror of the heap contents and the queue of outcomes it predicts.
    class min_heap_predictor;
        logic [KEY_BITS-1:0] keys [CAPACITY];
        int unsigned         held;
        t_res                outcomes[$];
        int unsigned         fail_count;

        function new();
            held       = 0;
            fail_count = 0;
        endfunction

        // Move the entry at pos toward the root while it is strictly smaller.
        function void sift_up(int unsigned pos);
            int unsigned         parent;
            logic [KEY_BITS-1:0] here;
            while (pos > 0) begin
                parent = (pos - 1) / 2;
                here   = keys[pos];
                if (!(here < keys[parent])) break;
                keys[pos]    = keys[parent];
                keys[parent] = here;
                pos          = parent;
            end
        endfunction

        // Move the entry at pos down through the smaller child while strictly larger.
        function void sift_down(int unsigned pos);
            int unsigned         left;
            int unsigned         right;
            int unsigned         pick;
            logic [KEY_BITS-1:0] here;
            forever begin
                left  = 2 * pos + 1;
                right = left + 1;
                if (left >= held) break;
                pick = left;
                if (right < held && !(keys[left] < keys[right])) pick = right;
                here = keys[pos];
                if (!(here > keys[pick])) break;
                keys[pos]  = keys[pick];
                keys[pick] = here;
                pos        = pick;
            end
        endfunction

        // Apply one accepted input transaction and queue the outcome it causes.
        function void record_action(logic [ACTION_W-1:0] act, logic [IN_KEY_W-1:0] key);
            t_res r;
            r.status     = ST_OK;
            r.result_key = '0;
            case (act)
                ACT_ENQ: begin
                    if (held >= CAPACITY) begin
                        r.status = ST_FULL;
                    end else begin
                        keys[held] = key[KEY_BITS-1:0];
                        held++;
                        sift_up(held - 1);
                    end
                end
                ACT_DEQ, ACT_PEEK: begin
                    if (held == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.result_key = keys[0];
                        if (act == ACT_DEQ) begin
                            held--;
                            keys[0] = keys[held];
                            sift_down(0);
                        end
                    end
                end
                default: begin
                end
            endcase
            r.entry_count = CNT_W'(held);
            outcomes.push_back(r);
        endfunction

        // Compare one accepted output transaction against the oldest outcome.
        function void compare_outcome(logic [STATUS_W-1:0] st, logic [IN_KEY_W-1:0] rkey,
                                      logic [CNT_W-1:0] cnt);
            t_res e;
            if (outcomes.size() == 0) begin
                $error("unexpected result: status %0d result_key %h entry_count %0d",
                       st, rkey, cnt);
                fail_count++;
                return;
            end
            e = outcomes.pop_front();
            if (st !== e.status) begin
                $error("status: expected %0d, actual %0d", e.status, st);
                fail_count++;
            end
            if (rkey !== e.result_key) begin
                $error("result_key: expected %h, actual %h", e.result_key, rkey);
                fail_count++;
            end
            if (cnt !== e.entry_count) begin
                $error("entry_count: expected %0d, actual %0d", e.entry_count, cnt);
                fail_count++;
            end
        endfunction
    endclass

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_in_valid   = 1'b0;
    logic [ACTION_W-1:0] i_action     = ACT_PEEK;
    logic [IN_KEY_W-1:0] i_key        = '0;
    logic                i_out_stall  = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic [STATUS_W-1:0] o_status;
    logic [IN_KEY_W-1:0] o_result_key;
    logic [CNT_W-1:0]    o_entry_count;

    // When set, neither side inserts idle cycles.
    bit quiet = 1'b0;

    min_heap_predictor pred = new();

    binary_min_heap_queue u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_key         (i_key),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_result_key  (o_result_key),
        .o_entry_count (o_entry_count)
    );

    // Clock generation.
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Random back-pressure on the output channel.
    always @(posedge i_clk) begin
        i_out_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 17);
    end

    // Check every accepted output transaction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            pred.compare_outcome(o_status, o_result_key, o_entry_count);
        end
    end

    // Overall time limit for the run.
    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Draw a key: small values for ties at small_pct percent, otherwise extremes or full-width random.
    function automatic logic [IN_KEY_W-1:0] draw_key(int small_pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < small_pct) return IN_KEY_W'($urandom_range(0, 15));
        r = $urandom_range(0, 99);
        if (r < 8)  return '0;
        if (r < 16) return KEY_ONES;
        if (r < 30) return {32'hFFFF_FFFF, 32'($urandom)};
        return {32'($urandom), 32'($urandom)};
    endfunction

    // Pick an action by percentage weights; the remainder goes to the unused code.
    function automatic logic [ACTION_W-1:0] pick_action(int enq_w, int deq_w, int peek_w);
        int r;
        r = $urandom_range(0, 99);
        if (r < enq_w)                  return ACT_ENQ;
        if (r < enq_w + deq_w)          return ACT_DEQ;
        if (r < enq_w + deq_w + peek_w) return ACT_PEEK;
        return ACT_UNUSED;
    endfunction

    // Present one input transaction, optionally after a random gap.
    task automatic send_action(logic [ACTION_W-1:0] act, logic [IN_KEY_W-1:0] key);
        if (!quiet && $urandom_range(0, 99) < 17) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_key      <= key;
        do @(posedge i_clk); while (o_in_stall);
        pred.record_action(act, key);
    endtask

    // Hold off the sender until every predicted outcome has been seen.
    task automatic wait_until_drained();
        i_in_valid <= 1'b0;
        while (pred.outcomes.size() != 0) @(posedge i_clk);
    endtask

    // Mixed random traffic.
    task automatic run_mixed(int n, int enq_w, int deq_w, int peek_w, int small_pct,
                             int quiet_lo, int quiet_hi);
        for (int i = 0; i < n; i++) begin
            quiet <= (i >= quiet_lo && i < quiet_hi);
            send_action(pick_action(enq_w, deq_w, peek_w), draw_key(small_pct));
        end
        quiet <= 1'b0;
    endtask

    // Main sequence.
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty heap, extremes, equal keys, the no-op code, drain to empty.
        send_action(ACT_PEEK, '0);
        send_action(ACT_DEQ, KEY_ONES);
        send_action(ACT_UNUSED, '0);
        send_action(ACT_ENQ, KEY_ONES);
        send_action(ACT_ENQ, '0);
        send_action(ACT_PEEK, KEY_ONES);
        send_action(ACT_ENQ, '0);
        send_action(ACT_ENQ, KEY_TOP);
        send_action(ACT_ENQ, 64'd5);
        send_action(ACT_ENQ, 64'd5);
        send_action(ACT_ENQ, 64'd5);
        send_action(ACT_UNUSED, KEY_ONES);
        send_action(ACT_PEEK, 64'h1234_5678_9ABC_DEF0);
        repeat (7) send_action(ACT_DEQ, KEY_ONES);
        send_action(ACT_DEQ, '0);
        send_action(ACT_PEEK, '0);

        // Random traffic that grows the heap, with one stretch free of idling.
        run_mixed(300, 55, 28, 12, 25, 100, 180);
        wait_until_drained();

        // Drain back to empty, which checks the sort order of what was built.
        while (pred.held > 0) begin
            send_action(pick_action(7, 86, 5), draw_key(20));
        end
        send_action(ACT_DEQ, draw_key(0));

        // Small heap with many ties.
        run_mixed(200, 45, 35, 15, 70, 0, 0);

        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pred.fail_count == 0 && pred.outcomes.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/hmq_pkg.sv
design/hmq_store.sv
design/hmq_ctrl.sv
design/binary_min_heap_queue.sv
test/binary_min_heap_queue_tb.sv
